>>> hdl/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Defining NO_ASSERTIONS turns every check into empty text.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BBA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BBA_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BBA_ASSERT(lbl, clk, rst_n, prop, msg)
`define BBA_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

>>> hdl/bba_pkg.sv
// Package of the buddy block allocator: field widths, codes, state type and helpers.
// Used by buddy_block_allocator_core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

    localparam int REQ_W      = 36;
    localparam int OFF_W      = 35;
    localparam int BYTES_W    = 36;
    localparam int STAT_W     = 2;
    localparam int MIN_W      = 21;
    localparam int HDR_W      = 13;
    localparam int NEED_W     = 37;
    localparam int SZ_W       = 46;
    localparam int SH_W       = 6;
    localparam int ULOG_W     = 5;
    localparam int SDATA_W    = 112;
    localparam int MDATA_W    = 80;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 21;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOSPACE  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ENCLOSED = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BADFREE  = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ALLOC = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER    = 1'b1;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_FIT, ST_PLAN, ST_GROW_RD, ST_GROW_WR,
        ST_SEARCH, ST_SCAN_RD, ST_SCAN_CK, ST_TAKE, ST_SPLIT_RD, ST_SPLIT_WR,
        ST_FREE_CHK, ST_ENC_RD, ST_ENC_CK, ST_MRG_RD, ST_MRG_CK,
        ST_MARK_RD, ST_MARK_WR, ST_OUT
    } t_state;

    // Log2 of the minimum size rounded up to a power of two; zero counts as one.
    function automatic logic [ULOG_W-1:0] f_unit_log(input logic [MIN_W-1:0] m);
        logic [MIN_W-1:0]  mm;
        logic [ULOG_W-1:0] res;
        mm  = (m == '0) ? '0 : m - MIN_W'(1);
        res = '0;
        for (int i = 0; i < MIN_W; i++) begin
            if (mm[i]) begin
                res = ULOG_W'(i + 1);
            end
        end
        return res;
    endfunction

    // Position of the highest set bit.
    function automatic logic [SH_W-1:0] f_top_bit(input logic [BYTES_W-1:0] v);
        logic [SH_W-1:0] res;
        res = '0;
        for (int i = 0; i < BYTES_W; i++) begin
            if (v[i]) begin
                res = SH_W'(i);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> hdl/buddy_block_allocator_core.sv
// Buddy block allocator: free marks in a RAM, per-level counts in flip-flops, one sequencer.
// Depends on bba_pkg, bba_mark_ram and assert_macros.svh.
//
//   channel  | direction | payload
//   s_axis   | in        | tdata: request_bytes, free_offset, free_bytes; tuser: opcode
//   m_axis   | out       | tdata: block_offset, granted_bytes, status
//   cfg      | in        | index, data (always ready)
//
// One item at a time. Allocate: fit, plan, a read/write per store growth step, a read/check
// per mark scanned at the chosen level, a take, a read/write per split. Free: a check, a
// read/check per enclosing level and per merge, a mark read/write. All mark accesses use
// the single RAM port. After reset every mark is zeroed before the first item is taken. A
// finished result waits in the output register while the next item is accepted.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module buddy_block_allocator_core #(
    parameter int SIZE_LEVELS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // request_bytes[35:0], free_offset[70:36], free_bytes[106:71], zero fill
    input  wire logic [bba_pkg::SDATA_W-1:0]     i_s_axis_tdata,
    // opcode
    input  wire logic                            i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // block_offset[34:0], granted_bytes[70:35], status[72:71], zero fill
    output logic [bba_pkg::MDATA_W-1:0]          o_m_axis_tdata,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [bba_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [bba_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bba_pkg::*;

    localparam int LW  = $clog2(SIZE_LEVELS);
    localparam int LW1 = $clog2(SIZE_LEVELS + 1);
    localparam int AW  = SIZE_LEVELS;
    localparam int JW  = SIZE_LEVELS - 1;
    localparam int CW  = SIZE_LEVELS;
    localparam logic [LW-1:0]  TOP_LVL  = LW'(SIZE_LEVELS - 1);
    localparam logic [LW1-1:0] TOP_LVL1 = LW1'(SIZE_LEVELS - 1);

    t_state r_state, n_state;

    logic [MIN_W-1:0]   r_min;
    logic [HDR_W-1:0]   r_hdr;
    logic [AW-1:0]      r_clr;
    logic [OFF_W-1:0]   r_foff, n_foff;
    logic [BYTES_W-1:0] r_fsz, n_fsz;
    logic [NEED_W-1:0]  r_need, n_need;
    logic [LW-1:0]      r_r, n_r;
    logic [LW-1:0]      r_sl, n_sl;
    logic [LW-1:0]      r_k, n_k;
    logic [JW-1:0]      r_j, n_j;
    logic [LW-1:0]      r_ak, n_ak;
    logic [JW-1:0]      r_aj, n_aj;
    logic [CW-1:0]      r_cnt [SIZE_LEVELS];
    logic [OFF_W-1:0]   r_res_off, n_res_off;
    logic [BYTES_W-1:0] r_res_gr, n_res_gr;
    logic [STAT_W-1:0]  r_res_st, n_res_st;
    logic               r_ovalid;
    logic [MDATA_W-1:0] r_odata;

    logic               mem_we, mem_wd, mem_rd;
    logic [AW-1:0]      mem_a;
    logic               cnt_up, cnt_dn;

    logic [ULOG_W-1:0]      ulog;
    logic [SH_W-1:0]        lg_r;
    logic [SZ_W-1:0]        sz_r;
    logic                   fit_short;
    logic [SIZE_LEVELS-1:0] nz;
    logic                   any_free;
    logic [LW-1:0]          lfl;
    logic [LW-1:0]          srch_k;
    logic [LW1-1:0]         fin;
    logic                   need_grow, grow_bad;
    logic [SZ_W-1:0]        u_sz, store_sz, fsz46, foff46;
    logic                   free_bad;
    logic [SH_W-1:0]        flg, fk6;
    logic [LW-1:0]          fk;
    logic [OFF_W-1:0]       fj35;
    logic [JW-1:0]          fj;
    logic [JW-1:0]          j_done;
    logic [SZ_W-1:0]        off_shift;
    logic                   out_load, s_acc;
    logic [LW1-1:0]         k_next1;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign out_load        = (r_state == ST_OUT) && (!r_ovalid || i_m_axis_tready);

    assign ulog      = f_unit_log(r_min);
    assign lg_r      = SH_W'(ulog) + SH_W'(r_r);
    assign sz_r      = SZ_W'(1) << lg_r;
    assign fit_short = sz_r < SZ_W'(r_need);

    always_comb begin
        any_free = 1'b0;
        lfl      = '0;
        srch_k   = '0;
        for (int k = 0; k < SIZE_LEVELS; k++) begin
            nz[k] = (r_cnt[k] != '0);
        end
        for (int k = 0; k < SIZE_LEVELS; k++) begin
            if (nz[k]) begin
                any_free = 1'b1;
                lfl      = LW'(k);
            end
        end
        for (int k = SIZE_LEVELS - 1; k >= 0; k--) begin
            if (nz[k] && (LW'(k) >= r_r)) begin
                srch_k = LW'(k);
            end
        end
    end

    assign fin       = ((r_sl > r_r) ? LW1'(r_sl) : LW1'(r_r)) + LW1'(1);
    assign need_grow = !any_free || (lfl < r_r);
    assign grow_bad  = (fin > TOP_LVL1) || ((SH_W'(ulog) + SH_W'(fin)) > SH_W'(OFF_W));

    assign u_sz     = SZ_W'(1) << ulog;
    assign store_sz = SZ_W'(1) << (SH_W'(ulog) + SH_W'(r_sl));
    assign fsz46    = SZ_W'(r_fsz);
    assign foff46   = SZ_W'(r_foff);
    assign free_bad = (fsz46 < u_sz) || ((r_fsz & (r_fsz - BYTES_W'(1))) != '0)
                    || ((foff46 & (fsz46 - SZ_W'(1))) != '0) || (fsz46 > store_sz)
                    || (foff46 > store_sz - fsz46);
    assign flg      = f_top_bit(r_fsz);
    assign fk6      = flg - SH_W'(ulog);
    assign fk       = fk6[LW-1:0];
    assign fj35     = r_foff >> flg;
    assign fj       = fj35[JW-1:0];
    assign k_next1  = LW1'(r_k) + LW1'(1);

    assign j_done    = (r_state == ST_TAKE) ? r_aj : (r_aj & ~JW'(1));
    assign off_shift = SZ_W'(j_done) << lg_r;

    bba_mark_ram #(.ADDR_W(AW)) u_marks (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_a),
        .i_wdata (mem_wd),
        .o_rdata (mem_rd)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == '1) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_acc) n_state = (i_s_axis_tuser == OP_ALLOC) ? ST_FIT : ST_FREE_CHK;
            end
            ST_FIT: begin
                if (!((r_r < TOP_LVL) && fit_short)) n_state = ST_PLAN;
            end
            ST_PLAN: begin
                if (fit_short) n_state = ST_OUT;
                else if (need_grow) n_state = grow_bad ? ST_OUT : ST_GROW_RD;
                else n_state = ST_SEARCH;
            end
            ST_GROW_RD:  n_state = ST_GROW_WR;
            ST_GROW_WR:  n_state = (r_ak >= r_r) ? ST_SEARCH : ST_GROW_RD;
            ST_SEARCH:   n_state = ST_SCAN_RD;
            ST_SCAN_RD:  n_state = ST_SCAN_CK;
            ST_SCAN_CK:  n_state = mem_rd ? ST_TAKE : ST_SCAN_RD;
            ST_TAKE:     n_state = (r_ak > r_r) ? ST_SPLIT_RD : ST_OUT;
            ST_SPLIT_RD: n_state = ST_SPLIT_WR;
            ST_SPLIT_WR: n_state = (r_ak > r_r) ? ST_SPLIT_RD : ST_OUT;
            ST_FREE_CHK: begin
                if (free_bad) n_state = ST_OUT;
                else if (fk < TOP_LVL) n_state = ST_ENC_RD;
                else n_state = ST_MARK_RD;
            end
            ST_ENC_RD: n_state = ST_ENC_CK;
            ST_ENC_CK: begin
                if (mem_rd) n_state = ST_OUT;
                else if (r_ak < TOP_LVL) n_state = ST_ENC_RD;
                else if (r_k < TOP_LVL) n_state = ST_MRG_RD;
                else n_state = ST_MARK_RD;
            end
            ST_MRG_RD: n_state = ST_MRG_CK;
            ST_MRG_CK: begin
                if (mem_rd && (k_next1 < TOP_LVL1)) n_state = ST_MRG_RD;
                else n_state = ST_MARK_RD;
            end
            ST_MARK_RD: n_state = ST_MARK_WR;
            ST_MARK_WR: n_state = ST_OUT;
            ST_OUT: begin
                if (out_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_foff    = r_foff;
        n_fsz     = r_fsz;
        n_need    = r_need;
        n_r       = r_r;
        n_sl      = r_sl;
        n_k       = r_k;
        n_j       = r_j;
        n_ak      = r_ak;
        n_aj      = r_aj;
        n_res_off = r_res_off;
        n_res_gr  = r_res_gr;
        n_res_st  = r_res_st;
        mem_we    = 1'b0;
        mem_wd    = 1'b0;
        mem_a     = ~({AW{1'b1}} >> r_ak) | AW'(r_aj);
        cnt_up    = 1'b0;
        cnt_dn    = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                mem_a  = r_clr;
            end
            ST_IDLE: begin
                if (s_acc) begin
                    n_need    = NEED_W'(i_s_axis_tdata[35:0]) + NEED_W'(r_hdr);
                    n_foff    = i_s_axis_tdata[70:36];
                    n_fsz     = i_s_axis_tdata[106:71];
                    n_r       = '0;
                    n_res_off = '0;
                    n_res_gr  = '0;
                    n_res_st  = STAT_OK;
                end
            end
            ST_FIT: begin
                if ((r_r < TOP_LVL) && fit_short) n_r = r_r + LW'(1);
            end
            ST_PLAN: begin
                if (fit_short || (need_grow && grow_bad)) begin
                    n_res_st = STAT_NOSPACE;
                end else if (need_grow) begin
                    n_ak = r_sl;
                    n_aj = JW'(1);
                end
            end
            ST_GROW_WR: begin
                mem_we = 1'b1;
                mem_wd = 1'b1;
                cnt_up = !mem_rd;
                n_sl   = r_sl + LW'(1);
                n_ak   = r_ak + LW'(1);
            end
            ST_SEARCH: begin
                n_ak = srch_k;
                n_aj = '0;
            end
            ST_SCAN_CK: begin
                if (!mem_rd) n_aj = r_aj + JW'(1);
            end
            ST_TAKE: begin
                mem_we = 1'b1;
                cnt_dn = 1'b1;
                if (r_ak > r_r) begin
                    n_ak = r_ak - LW'(1);
                    n_aj = (r_aj << 1) | JW'(1);
                end else begin
                    n_res_off = off_shift[OFF_W-1:0];
                    n_res_gr  = sz_r[BYTES_W-1:0];
                end
            end
            ST_SPLIT_WR: begin
                mem_we = 1'b1;
                mem_wd = 1'b1;
                cnt_up = !mem_rd;
                if (r_ak > r_r) begin
                    n_ak = r_ak - LW'(1);
                    n_aj = ((r_aj >> 1) << 2) | JW'(1);
                end else begin
                    n_res_off = off_shift[OFF_W-1:0];
                    n_res_gr  = sz_r[BYTES_W-1:0];
                end
            end
            ST_FREE_CHK: begin
                if (free_bad) begin
                    n_res_st = STAT_BADFREE;
                end else begin
                    n_k = fk;
                    n_j = fj;
                    if (fk < TOP_LVL) begin
                        n_ak = fk + LW'(1);
                        n_aj = fj >> 1;
                    end else begin
                        n_ak = fk;
                        n_aj = fj;
                    end
                end
            end
            ST_ENC_CK: begin
                if (mem_rd) begin
                    n_res_st = STAT_ENCLOSED;
                end else if (r_ak < TOP_LVL) begin
                    n_ak = r_ak + LW'(1);
                    n_aj = r_aj >> 1;
                end else begin
                    n_ak = r_k;
                    n_aj = (r_k < TOP_LVL) ? (r_j ^ JW'(1)) : r_j;
                end
            end
            ST_MRG_CK: begin
                if (mem_rd) begin
                    mem_we = 1'b1;
                    cnt_dn = 1'b1;
                    n_k    = r_k + LW'(1);
                    n_j    = r_j >> 1;
                    n_ak   = r_k + LW'(1);
                    n_aj   = (k_next1 < TOP_LVL1) ? ((r_j >> 1) ^ JW'(1)) : (r_j >> 1);
                end else begin
                    n_ak = r_k;
                    n_aj = r_j;
                end
            end
            ST_MARK_WR: begin
                mem_we = 1'b1;
                mem_wd = 1'b1;
                cnt_up = !mem_rd;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_min    <= MIN_W'(4096);
            r_hdr    <= HDR_W'(16);
            r_sl     <= '0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < SIZE_LEVELS; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_sl    <= n_sl;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_MIN_ALLOC) begin
                    r_min <= i_cfg_data;
                end else if (i_cfg_index == CFG_HEADER) begin
                    r_hdr <= i_cfg_data[HDR_W-1:0];
                end
            end
            if (cnt_up) begin
                r_cnt[r_ak] <= r_cnt[r_ak] + CW'(1);
            end else if (cnt_dn) begin
                r_cnt[r_ak] <= r_cnt[r_ak] - CW'(1);
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_foff    <= n_foff;
        r_fsz     <= n_fsz;
        r_need    <= n_need;
        r_r       <= n_r;
        r_k       <= n_k;
        r_j       <= n_j;
        r_ak      <= n_ak;
        r_aj      <= n_aj;
        r_res_off <= n_res_off;
        r_res_gr  <= n_res_gr;
        r_res_st  <= n_res_st;
        if (out_load) begin
            r_odata <= {(MDATA_W - OFF_W - BYTES_W - STAT_W)'(0), r_res_st, r_res_gr, r_res_off};
        end
    end

    `BBA_ASSERT(a_accept_starts_work, i_clk, i_rst_n, s_acc |=> (r_state != ST_IDLE), "item accepted but sequencer stayed idle")
    `BBA_NEVER(a_count_underflow, i_clk, i_rst_n, cnt_dn && (r_cnt[r_ak] == '0), "free mark count underflow")
    `BBA_NEVER(a_store_level_range, i_clk, i_rst_n, r_sl > TOP_LVL, "store level beyond the top level")

endmodule

`default_nettype wire

>>> hdl/bba_mark_ram.sv
// Single-port RAM of one-bit free marks with a registered read.
// Used by buddy_block_allocator_core; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module bba_mark_ram #(
    parameter int ADDR_W = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic              i_wdata,
    output logic                   o_rdata
);

    logic r_mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

>>> tb/buddy_block_allocator_core_tb.sv
// Testbench of buddy_block_allocator_core: drives requests and register writes, and checks results.
// Results are compared against a buddy allocator predictor kept in a small scoreboard class.
// Depends on bba_pkg and the allocator RTL.
`timescale 1ns / 1ps

module buddy_block_allocator_core_tb;
    import bba_pkg::*;

    localparam int LEVELS    = 16;
    localparam int MARKS     = 1 << LEVELS;
    localparam int WDOG_MAX  = 400000;
    localparam longint unsigned STORE_CAP = 64'd1 << 35;
    localparam longint unsigned M35 = (64'd1 << 35) - 1;
    localparam longint unsigned M36 = (64'd1 << 36) - 1;

    typedef struct packed {
        logic [OFF_W-1:0]   offset;
        logic [BYTES_W-1:0] bytes;
        logic [STAT_W-1:0]  status;
    } grant_t;

    class alloc_scoreboard;
        bit               marks[MARKS];
        int unsigned      level_free[LEVELS];
        int unsigned      store_lvl;
        int unsigned      top_free_lvl;
        bit               some_free;
        longint unsigned  min_bytes;
        longint unsigned  hdr_bytes;
        grant_t           pending_q[$];

        function new();
            store_lvl    = 0;
            top_free_lvl = 0;
            some_free    = 0;
            min_bytes    = 4096;
            hdr_bytes    = 16;
            foreach (level_free[k]) level_free[k] = 0;
        endfunction

        function int unsigned idx(int unsigned k, longint unsigned j);
            return (MARKS - (MARKS >> k)) + int'(j);
        endfunction

        function void mark(int unsigned k, longint unsigned j, bit v);
            int unsigned n;
            n = idx(k, j);
            if (marks[n] != v) begin
                if (v) level_free[k]++;
                else level_free[k]--;
            end
            marks[n] = v;
        endfunction

        function void recount();
            some_free    = 0;
            top_free_lvl = 0;
            for (int k = 0; k < LEVELS; k++) begin
                if (level_free[k] != 0) begin
                    some_free    = 1;
                    top_free_lvl = k;
                end
            end
        endfunction

        function longint unsigned unit();
            longint unsigned m;
            longint unsigned u;
            m = (min_bytes == 0) ? 1 : min_bytes;
            u = 1;
            while (u < m) u <<= 1;
            return u;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            if (index == CFG_MIN_ALLOC) min_bytes = data;
            else if (index == CFG_HEADER) hdr_bytes = data[HDR_W-1:0];
        endfunction

        function grant_t make(longint unsigned off, longint unsigned b, logic [STAT_W-1:0] s);
            grant_t g;
            g.offset = off & M35;
            g.bytes  = b & M36;
            g.status = s;
            return g;
        endfunction

        function grant_t allocate(longint unsigned req);
            longint unsigned u;
            longint unsigned need;
            longint unsigned j;
            int unsigned     r;
            int unsigned     k;
            int unsigned     fin;
            bit              found;
            u = unit();
            need = req + hdr_bytes;
            r = 0;
            j = 0;
            found = 0;
            while (r < LEVELS - 1 && (u << r) < need) r++;
            if ((u << r) < need) return make(0, 0, STAT_NOSPACE);
            if (!some_free || top_free_lvl < r) begin
                fin = (store_lvl > r) ? store_lvl + 1 : r + 1;
                if (fin > LEVELS - 1 || (u << fin) > STORE_CAP) return make(0, 0, STAT_NOSPACE);
                while (!some_free || top_free_lvl < r) begin
                    mark(store_lvl, 1, 1);
                    top_free_lvl = store_lvl;
                    some_free = 1;
                    store_lvl++;
                end
            end
            for (k = r; k < LEVELS && !found; k++) begin
                if (level_free[k] != 0) begin
                    for (j = 0; j < (64'd1 << (LEVELS - 1 - k)); j++) begin
                        if (marks[idx(k, j)]) begin
                            found = 1;
                            break;
                        end
                    end
                end
            end
            if (!found) return make(0, 0, STAT_NOSPACE);
            k--;
            mark(k, j, 0);
            while (k > r) begin
                k--;
                j <<= 1;
                mark(k, j + 1, 1);
            end
            recount();
            return make(j * (u << r), u << r, STAT_OK);
        endfunction

        function grant_t release_block(longint unsigned off, longint unsigned sz);
            longint unsigned u;
            longint unsigned whole;
            longint unsigned j;
            int unsigned     k;
            u = unit();
            whole = u << store_lvl;
            if (sz < u || (sz & (sz - 1)) != 0 || (off & (sz - 1)) != 0 || sz > whole ||
                off > whole - sz)
                return make(0, 0, STAT_BADFREE);
            k = 0;
            while ((u << k) < sz) k++;
            j = off / sz;
            for (int a = k + 1; a < LEVELS; a++) begin
                if (marks[idx(a, j >> (a - k))]) return make(0, 0, STAT_ENCLOSED);
            end
            while (k < LEVELS - 1 && marks[idx(k, j ^ 1)]) begin
                mark(k, j ^ 1, 0);
                j >>= 1;
                k++;
            end
            mark(k, j, 1);
            recount();
            return make(0, 0, STAT_OK);
        endfunction

        function grant_t note_request(logic op, longint unsigned req, longint unsigned off,
                                      longint unsigned sz);
            grant_t g;
            if (op == OP_ALLOC) g = allocate(req & M36);
            else g = release_block(off & M35, sz & M36);
            pending_q.push_back(g);
            return g;
        endfunction

        function string check_result(logic [MDATA_W-1:0] data);
            grant_t got;
            grant_t want;
            got.offset = data[34:0];
            got.bytes  = data[70:35];
            got.status = data[72:71];
            if (pending_q.size() == 0)
                return $sformatf("unexpected result %h", data);
            want = pending_q.pop_front();
            if (got.offset != want.offset || got.bytes != want.bytes ||
                got.status != want.status)
                return $sformatf("got off=%h bytes=%h st=%0d, want off=%h bytes=%h st=%0d",
                                 got.offset, got.bytes, got.status,
                                 want.offset, want.bytes, want.status);
            return "";
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_valid;
    logic                  s_ready;
    logic [SDATA_W-1:0]    s_data;
    logic                  s_user;
    logic                  m_valid;
    logic                  m_ready;
    logic [MDATA_W-1:0]    m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    alloc_scoreboard  sb;
    int               err_count;
    int               send_idle_pct;
    int               recv_idle_pct;
    int               quiet_cycles;
    longint unsigned  live_off[$];
    longint unsigned  live_size[$];

    buddy_block_allocator_core #(.SIZE_LEVELS(LEVELS)) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    always @(negedge i_clk) begin
        m_ready <= (recv_idle_pct == 0) ? 1'b1 : ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n && m_valid && m_ready) begin
            msg = sb.check_result(m_data);
            if (msg != "") report_mismatch(msg);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WDOG_MAX) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic longint unsigned rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_beat(input logic op, input longint unsigned req,
                             input longint unsigned off, input longint unsigned sz,
                             output grant_t g);
        int gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            s_valid = 1'b0;
        end
        @(negedge i_clk);
        s_valid = 1'b1;
        s_user  = op;
        s_data  = '0;
        s_data[35:0]   = req[35:0];
        s_data[70:36]  = off[34:0];
        s_data[106:71] = sz[35:0];
        do @(posedge i_clk); while (!s_ready);
        g = sb.note_request(op, req, off, sz);
        if (op == OP_ALLOC && g.status == STAT_OK) begin
            live_off.push_back(g.offset);
            live_size.push_back(g.bytes);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_valid = 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        do @(posedge i_clk); while (!cfg_ready);
        sb.write_reg(index, data);
        @(negedge i_clk);
        cfg_valid = 1'b0;
        live_off.delete();
        live_size.delete();
    endtask

    task automatic random_beat();
        grant_t          g;
        longint unsigned u;
        longint unsigned req;
        longint unsigned off;
        longint unsigned sz;
        int              pick;
        int              n;
        u = sb.unit();
        pick = $urandom_range(99);
        if (pick < 50) begin
            n = $urandom_range(9);
            if (n < 6) req = $urandom_range(0, int'(u) * 3);
            else if (n < 8) req = $urandom_range(0, 255);
            else if (n < 9) req = rand64() % (u * 64 + 1);
            else req = rand64() & M36;
            send_beat(OP_ALLOC, req, rand64(), rand64(), g);
        end else if (pick < 85 && live_off.size() != 0) begin
            n = $urandom_range(live_off.size() - 1);
            off = live_off[n];
            sz = live_size[n];
            live_off.delete(n);
            live_size.delete(n);
            if ($urandom_range(9) == 0 && sz >= 2 * u) begin
                sz = sz / 2;
                off = off + sz * $urandom_range(1);
            end
            send_beat(OP_FREE, rand64(), off, sz, g);
        end else if (pick < 93) begin
            sz = u << $urandom_range(0, 15);
            off = sz * $urandom_range(0, 7);
            send_beat(OP_FREE, rand64(), off, sz, g);
        end else begin
            send_beat(logic'($urandom_range(1)), rand64() & M36, rand64() & M35,
                      rand64() & M36, g);
        end
    endtask

    initial begin
        grant_t g;
        grant_t a;
        int     done;
        sb = new();
        err_count = 0;
        quiet_cycles = 0;
        send_idle_pct = 13;
        recv_idle_pct = 88;
        i_rst_n = 1'b0;
        s_valid = 1'b0;
        s_user = OP_ALLOC;
        s_data = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MIN_ALLOC;
        cfg_data = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_beat(OP_ALLOC, 0, 0, 0, g);
        send_beat(OP_ALLOC, 4096, 0, 0, a);
        send_beat(OP_FREE, 0, 0, 3000, g);
        send_beat(OP_FREE, 0, 4096, 8192, g);
        send_beat(OP_FREE, 0, 0, 2048, g);
        send_beat(OP_FREE, 0, 0, 64'd1 << 36, g);
        send_beat(OP_FREE, 0, M35, 64'd1 << 35, g);
        send_beat(OP_FREE, 0, a.offset, a.bytes, g);
        send_beat(OP_FREE, 0, a.offset, a.bytes / 2, g);
        send_beat(OP_FREE, 0, 0, 4096, g);
        send_beat(OP_FREE, 0, 0, 4096, g);
        send_beat(OP_ALLOC, M36, 0, 0, g);
        send_beat(OP_ALLOC, 64'd1 << 26, 0, 0, g);
        send_beat(OP_ALLOC, 64'd1 << 27, 0, 0, g);
        send_beat(OP_ALLOC, 1, M35, M36, g);
        send_beat(OP_FREE, M36, M35, M36, g);
        send_beat(OP_FREE, 0, 0, 0, g);
        drain();

        done = 0;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                1: begin
                    write_reg(CFG_MIN_ALLOC, 21'd1);
                    write_reg(CFG_HEADER, 21'd0);
                end
                2: begin
                    write_reg(CFG_MIN_ALLOC, 21'd0);
                    write_reg(CFG_HEADER, 21'd4096);
                end
                3: begin
                    write_reg(CFG_MIN_ALLOC, 21'd1048576);
                    write_reg(CFG_HEADER, 21'd0);
                end
                4: begin
                    write_reg(CFG_MIN_ALLOC, 21'd3000);
                    write_reg(CFG_HEADER, 21'd100);
                end
                default: ;
            endcase
            repeat (220) begin
                if (done == 360) begin
                    send_idle_pct = 88;
                    recv_idle_pct = 13;
                end else if (done == 720) begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                random_beat();
                done++;
            end
            drain();
        end

        repeat (2000) @(posedge i_clk);
        if (sb.pending_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", sb.pending_q.size()));
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
